/* hw/rtl/u8dt_pkg.sv */
// Shared types, constants and the look-alike table for the UTF-8 decoder.
package u8dt_pkg;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;

	typedef struct packed {
		logic        produce;
		logic [15:0] unit;
		logic        last;
		logic [1:0]  pend_next;
		logic [9:0]  part_next;
	} dec_result_t;

	function automatic logic [15:0] look_alike(input logic [15:0] c);
		logic [15:0] r;
		case (c)
			16'h0410: r = 16'h0041;
			16'h0412: r = 16'h0042;
			16'h0415: r = 16'h0045;
			16'h041a: r = 16'h004b;
			16'h041c: r = 16'h004d;
			16'h041d: r = 16'h0048;
			16'h041e: r = 16'h004f;
			16'h0420: r = 16'h0050;
			16'h0421: r = 16'h0043;
			16'h0422: r = 16'h0054;
			16'h0425: r = 16'h0058;
			16'h0430: r = 16'h0061;
			16'h0435: r = 16'h0065;
			16'h043e: r = 16'h006f;
			16'h0440: r = 16'h0070;
			16'h0441: r = 16'h0063;
			16'h0445: r = 16'h0078;
			16'h00aa: r = 16'h0061;
			16'h00ba: r = 16'h006f;
			16'h0060: r = 16'h0027;
			default:  r = c;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/u8dt_decode.sv */
// Per-byte decode step: sequence tracking, zero padding at end of string, look-alike map.
module u8dt_decode (
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  logic [1:0]            pend,
	input  logic [9:0]            part,
	output u8dt_pkg::dec_result_t res
);

	logic        done;
	logic [15:0] unit;
	logic [1:0]  np;
	logic [9:0]  npv;

	always_comb begin
		done = 1'b0;
		unit = 16'd0;
		np   = pend;
		npv  = part;
		case (pend)
			u8dt_pkg::PEND_ONE: begin
				unit = {part, in_byte[5:0]};
				done = 1'b1;
				np   = u8dt_pkg::PEND_NONE;
				npv  = 10'd0;
			end
			u8dt_pkg::PEND_NONE: begin
				if (in_byte[7:5] == u8dt_pkg::LEAD2_TAG) begin
					npv = {5'd0, in_byte[4:0]};
					np  = u8dt_pkg::PEND_ONE;
				end else if (in_byte[7:4] == u8dt_pkg::LEAD3_TAG) begin
					npv = {6'd0, in_byte[3:0]};
					np  = u8dt_pkg::PEND_TWO;
				end else begin
					unit = {8'd0, in_byte};
					done = 1'b1;
				end
			end
			default: begin
				// two still owed (three never arises, treated the same)
				npv = {part[3:0], in_byte[5:0]};
				np  = u8dt_pkg::PEND_ONE;
			end
		endcase

		// string ends mid-sequence: missing bytes are zero
		if (!done && in_last) begin
			if (np == u8dt_pkg::PEND_ONE)
				unit = {npv, 6'd0};
			else
				unit = {npv[3:0], 12'd0};
			done = 1'b1;
			np   = u8dt_pkg::PEND_NONE;
			npv  = 10'd0;
		end

		res.produce   = done;
		res.unit      = u8dt_pkg::look_alike(unit);
		res.last      = in_last;
		res.pend_next = np;
		res.part_next = npv;
	end

endmodule

/* hw/rtl/utf8_decode_transliterate.sv */
// UTF-8 to 16-bit code unit decoder with look-alike transliteration, top level.
// Takes one UTF-8 byte per cycle while in_ready is high and gives at most one 16-bit code
// unit per byte, registered from the byte that finishes the unit. Two- and three-byte
// sequences are decoded without checking continuation bytes; a string that ends inside
// a sequence gives one unit with the missing bits as zero. The byte decode and table
// lookup sit between the input handshake and an output register backed by a one-item
// skid register, so bytes keep flowing at one per cycle while out_ready is high and at
// least one more byte is taken after the output stalls.
module utf8_decode_transliterate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        out_last
);

	logic [1:0]  pend_q;
	logic [9:0]  part_q;
	logic        out_v_q;
	logic [15:0] out_unit_q;
	logic        out_last_q;
	logic        skid_v_q;
	logic [15:0] skid_unit_q;
	logic        skid_last_q;

	u8dt_pkg::dec_result_t dec;
	logic accept;
	logic take;
	logic pop;

	u8dt_decode u_decode (
		.in_byte (in_byte),
		.in_last (in_last),
		.pend    (pend_q),
		.part    (part_q),
		.res     (dec)
	);

	assign in_ready = !skid_v_q;
	assign accept   = in_valid && in_ready;
	assign take     = accept && dec.produce;
	assign pop      = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= u8dt_pkg::PEND_NONE;
			part_q <= 10'd0;
		end else if (accept) begin
			pend_q <= dec.pend_next;
			part_q <= dec.part_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= take;
			end
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_unit_q <= skid_unit_q;
				out_last_q <= skid_last_q;
			end else if (take) begin
				out_unit_q <= dec.unit;
				out_last_q <= dec.last;
			end
		end else if (take) begin
			skid_unit_q <= dec.unit;
			skid_last_q <= dec.last;
		end
	end

	assign out_valid = out_v_q;
	assign code_unit = out_unit_q;
	assign out_last  = out_last_q;

endmodule

/* hw/rtl/u8dt_checker.sv */
// Port-level checks for the UTF-8 decoder, bound to the top level.
module u8dt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  in_byte,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic        out_last
);

	// a waiting input item keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_last))
		else $error("waiting input item changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(out_last))
		else $error("stalled output item changed");

	// a byte flagged last always finishes a unit
	a_last_gives_unit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid)
		else $error("last byte gave no item");

	// input only stalls once the output holds an item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	a_no_invented_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("output item without input");

endmodule

bind utf8_decode_transliterate u8dt_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_byte   (in_byte),
	.in_last   (in_last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.code_unit (code_unit),
	.out_last  (out_last)
);
